/* rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// holds field widths, status and kind codes, table entry layout and the
// command / status structs between controller and datapath
// ----------------------------------------------------------------------------
package ffba_pkg;

   localparam int DEFAULT_POOL_BYTES    = 1024 * 1024;
   localparam int DEFAULT_TABLE_ENTRIES = 128;

   localparam int FIELD_W  = 21;
   localparam int STATUS_W = 3;
   localparam int TDATA_W  = 48;

   // request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_REUSED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_APPENDED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd5;

   // one block table entry
   typedef struct packed {
      logic               is_free;
      logic [FIELD_W-1:0] size;
      logic [FIELD_W-1:0] offset;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;         // latch a new request, restart the scan
      logic scan;         // walk the table one entry per cycle
      logic finish_hit;   // update the matching entry and load the result
      logic finish_miss;  // append or report, and load the result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic match;        // entry under test satisfies the request
      logic scan_done;    // all used entries looked at, none matched
   } stat_type;

endpackage

/* rtl/ffba_ctrl.sv */
// ----------------------------------------------------------------------------
// ffba_ctrl: allocator control state machine
// sequences accept, table scan and completion, and owns the result valid flag
// ----------------------------------------------------------------------------
module ffba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  ffba_pkg::stat_type stat,
   output ffba_pkg::cmd_type  cmd
);
   import ffba_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_HIT,
      S_MISS
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.match) begin
               state_in = S_HIT;
            end else if (stat.scan_done) begin
               state_in = S_MISS;
            end
         end
         S_HIT: begin
            if (out_free) begin
               cmd.finish_hit = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_MISS: begin
            if (out_free) begin
               cmd.finish_miss = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/ffba_dpath.sv */
// ----------------------------------------------------------------------------
// ffba_dpath: allocator datapath
// block table memory, scan pointer, match logic, bump offset and result regs
// ----------------------------------------------------------------------------
module ffba_dpath #(
   parameter int POOL_BYTES    = ffba_pkg::DEFAULT_POOL_BYTES,
   parameter int TABLE_ENTRIES = ffba_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ffba_pkg::cmd_type                     cmd,
   output ffba_pkg::stat_type                    stat,
   input  logic                                  kind,
   input  logic [ffba_pkg::FIELD_W-1:0]          request_size,
   input  logic [ffba_pkg::FIELD_W-1:0]          release_offset,
   output logic [ffba_pkg::STATUS_W-1:0]         status,
   output logic [ffba_pkg::FIELD_W-1:0]          block_offset,
   output logic [ffba_pkg::FIELD_W-1:0]          block_size
);
   import ffba_pkg::*;

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   // block table
   entry_type table_mem [TABLE_ENTRIES];

   // latched request
   logic               kind_ff, kind_in;
   logic [FIELD_W-1:0] size_ff, size_in;
   logic [FIELD_W-1:0] off_ff, off_in;

   // scan pipeline
   logic [CW-1:0] rd_addr_ff, rd_addr_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   entry_type     rd_data_ff;
   logic          read_en;

   // allocator state
   logic [CW-1:0]      used_ff, used_in;
   logic [FIELD_W-1:0] bytes_ff, bytes_in;

   // result
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [FIELD_W-1:0]  boff_ff, boff_in;
   logic [FIELD_W-1:0]  bsize_ff, bsize_in;

   // table write port
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;

   logic           fits, same_off, more_left;
   logic [FIELD_W:0] bump_sum;
   logic           no_space, full;

   assign fits      = rd_data_ff.is_free && (rd_data_ff.size >= size_ff);
   assign same_off  = (rd_data_ff.offset == off_ff);
   assign more_left = (rd_addr_ff < used_ff);

   assign stat.match     = rd_valid_ff && ((kind_ff == KIND_FREE) ? same_off : fits);
   assign stat.scan_done = !rd_valid_ff && !more_left;

   assign read_en = cmd.scan && !stat.match && more_left;

   assign bump_sum = {1'b0, bytes_ff} + {1'b0, size_ff};
   assign no_space = bump_sum > (FIELD_W + 1)'(POOL_BYTES);
   assign full     = used_ff >= CW'(TABLE_ENTRIES);

   always_comb begin
      kind_in     = kind_ff;
      size_in     = size_ff;
      off_in      = off_ff;
      rd_addr_in  = rd_addr_ff;
      rd_valid_in = rd_valid_ff;
      rd_idx_in   = rd_idx_ff;
      used_in     = used_ff;
      bytes_in    = bytes_ff;
      status_in   = status_ff;
      boff_in     = boff_ff;
      bsize_in    = bsize_ff;
      wr_en       = 1'b0;
      wr_addr     = rd_idx_ff;
      wr_data     = rd_data_ff;

      if (cmd.load) begin
         kind_in     = kind;
         size_in     = request_size;
         off_in      = release_offset;
         rd_addr_in  = '0;
         rd_valid_in = 1'b0;
      end

      if (cmd.scan && !stat.match) begin
         rd_valid_in = more_left;
         if (more_left) begin
            rd_idx_in  = rd_addr_ff[AW-1:0];
            rd_addr_in = rd_addr_ff + CW'(1);
         end
      end

      if (cmd.finish_hit) begin
         // release sets the flag, reuse clears it; size is never split
         wr_en           = 1'b1;
         wr_addr         = rd_idx_ff;
         wr_data.is_free = (kind_ff == KIND_FREE);
         status_in       = (kind_ff == KIND_FREE) ? ST_RELEASED : ST_REUSED;
         boff_in         = rd_data_ff.offset;
         bsize_in        = rd_data_ff.size;
         rd_valid_in     = 1'b0;
      end

      if (cmd.finish_miss) begin
         status_in = ST_NOT_FOUND;
         boff_in   = '0;
         bsize_in  = '0;
         if (kind_ff == KIND_ALLOC) begin
            if (no_space) begin
               status_in = ST_NO_SPACE;
            end else if (full) begin
               status_in = ST_TABLE_FULL;
            end else begin
               wr_en           = 1'b1;
               wr_addr         = used_ff[AW-1:0];
               wr_data.is_free = 1'b0;
               wr_data.size    = size_ff;
               wr_data.offset  = bytes_ff;
               used_in         = used_ff + CW'(1);
               bytes_in        = bump_sum[FIELD_W-1:0];
               status_in       = ST_APPENDED;
               boff_in         = bytes_ff;
               bsize_in        = size_ff;
            end
         end
      end
   end

   // table memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (read_en) begin
         rd_data_ff <= table_mem[rd_addr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         used_ff     <= '0;
         bytes_ff    <= '0;
      end else begin
         rd_valid_ff <= rd_valid_in;
         used_ff     <= used_in;
         bytes_ff    <= bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      size_ff    <= size_in;
      off_ff     <= off_in;
      rd_addr_ff <= rd_addr_in;
      rd_idx_ff  <= rd_idx_in;
      status_ff  <= status_in;
      boff_ff    <= boff_in;
      bsize_ff   <= bsize_in;
   end

   assign status       = status_ff;
   assign block_offset = boff_ff;
   assign block_size   = bsize_ff;

endmodule

/* rtl/first_fit_block_allocator.sv */
// a request runs from acceptance through the table scan into a hit or miss state,
// which loads the result once the output register is free; the scan reads one
// table entry per cycle
// throughput: one request at a time; the next request is taken once the result is
// loaded into the output register, even while that result still waits for rsp_tready
// reset: synchronous, clears entry count, bump offset and handshake state;
// the table itself is not cleared, only entries below the entry count are ever read
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit allocator over a block table
// allocate reuses the first free block large enough (no split) or appends
// at the bump offset; free marks the first block at the given offset free
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
   parameter int POOL_BYTES    = ffba_pkg::DEFAULT_POOL_BYTES,
   parameter int TABLE_ENTRIES = ffba_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ffba_pkg::TDATA_W-1:0]    req_tdata,  // request_size, release_offset, pad
   input  logic                            req_tuser,  // kind
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ffba_pkg::TDATA_W-1:0]    rsp_tdata,  // block_offset, block_size, pad
   output logic [ffba_pkg::STATUS_W-1:0]   rsp_tuser   // status
);
   import ffba_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   logic [FIELD_W-1:0]  block_offset;
   logic [FIELD_W-1:0]  block_size;
   logic [STATUS_W-1:0] status;

   // controller: accept, scan, completion and result valid
   ffba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath: table, scan pointer, bump offset, result registers
   ffba_dpath #(
      .POOL_BYTES    (POOL_BYTES),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .kind           (req_tuser),
      .request_size   (req_tdata[FIELD_W-1:0]),
      .release_offset (req_tdata[2*FIELD_W-1:FIELD_W]),
      .status         (status),
      .block_offset   (block_offset),
      .block_size     (block_size)
   );

   // result beat packing, pad bits zero
   assign rsp_tdata = {{(TDATA_W - 2*FIELD_W){1'b0}}, block_size, block_offset};
   assign rsp_tuser = status;

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the first-fit block allocator
// streams allocate and free beats into the block, predicts each result from
// a local copy of the block table and checks every result beat in order
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ffba_pkg::*;

   localparam int POOL_BYTES    = DEFAULT_POOL_BYTES;
   localparam int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES;
   localparam int DIRECTED_ITEMS = 14;
   localparam int RANDOM_ITEMS   = 2000;
   localparam int PLANNED_ITEMS  = DIRECTED_ITEMS + RANDOM_ITEMS + 3;
   localparam int STALL_AT       = 1700;   // request count that triggers the long hold
   localparam int STALL_CYCLES   = 400;

   // one request as queued for the driver
   typedef struct packed {
      logic               kind;
      logic [FIELD_W-1:0] want;   // request_size
      logic [FIELD_W-1:0] at;     // release_offset
   } alloc_request_type;

   // one result as predicted or as seen on the result channel
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0]  offset;
      logic [FIELD_W-1:0]  size;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata = '0;    // request_size, release_offset, pad
   logic               req_tuser = 1'b0;  // kind
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [TDATA_W-1:0]  rsp_tdata;        // block_offset, block_size, pad
   logic [STATUS_W-1:0] rsp_tuser;        // status

   first_fit_block_allocator #(
      .POOL_BYTES    (POOL_BYTES),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow of the block table, advanced once per accepted request beat
   logic [FIELD_W-1:0] slot_offset [TABLE_ENTRIES];
   logic [FIELD_W-1:0] slot_size   [TABLE_ENTRIES];
   logic               slot_free   [TABLE_ENTRIES];
   int                 slots_used  = 0;
   logic [FIELD_W-1:0] bump_offset = '0;

   alloc_request_type pending_requests [$];
   grant_type         expected_grants  [$];

   int unsigned requests_accepted = 0;
   int unsigned results_checked   = 0;
   int unsigned mismatch_count    = 0;
   int unsigned status_seen [6]   = '{default: 0};
   logic        req_beat_taken    = 1'b0;
   int unsigned stall_left        = 0;
   bit          stall_done        = 1'b0;

   // first-fit decision plus table update for one request
   function automatic grant_type predict_grant(alloc_request_type r);
      grant_type g;
      bit        hit;
      g   = '0;
      hit = 1'b0;
      if (r.kind == KIND_ALLOC) begin
         // lowest free entry that is big enough, never split
         for (int i = 0; i < slots_used && !hit; i++) begin
            if (slot_free[i] && slot_size[i] >= r.want) begin
               hit          = 1'b1;
               slot_free[i] = 1'b0;
               g            = '{ST_REUSED, slot_offset[i], slot_size[i]};
            end
         end
         if (!hit) begin
            // pool overflow wins over a full table
            if (int'(bump_offset) + int'(r.want) > POOL_BYTES) begin
               g.status = ST_NO_SPACE;
            end else if (slots_used >= TABLE_ENTRIES) begin
               g.status = ST_TABLE_FULL;
            end else begin
               slot_offset[slots_used] = bump_offset;
               slot_size[slots_used]   = r.want;
               slot_free[slots_used]   = 1'b0;
               slots_used++;
               g           = '{ST_APPENDED, bump_offset, r.want};
               bump_offset = bump_offset + r.want;
            end
         end
      end else begin
         // first match by offset only, already free or not
         for (int i = 0; i < slots_used && !hit; i++) begin
            if (slot_offset[i] == r.at) begin
               hit          = 1'b1;
               slot_free[i] = 1'b1;
               g            = '{ST_RELEASED, slot_offset[i], slot_size[i]};
            end
         end
         if (!hit) g.status = ST_NOT_FOUND;
      end
      return g;
   endfunction

   // the unused field of each beat carries random bits
   task automatic queue_request(logic kind, logic [FIELD_W-1:0] value);
      alloc_request_type r;
      r.kind = kind;
      r.want = (kind == KIND_ALLOC) ? value : FIELD_W'($urandom);
      r.at   = (kind == KIND_FREE)  ? value : FIELD_W'($urandom);
      pending_requests.push_back(r);
   endtask

   // request driver: a new beat goes up only once the last one was taken
   always @(negedge clock) begin
      alloc_request_type r;
      int unsigned       idle_pct;
      case (requests_accepted * 3 / PLANNED_ITEMS)
         0:       idle_pct = 6;
         1:       idle_pct = 81;
         default: idle_pct = 0;
      endcase
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_beat_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            r = pending_requests.pop_front();
            req_tuser  <= r.kind;
            req_tdata  <= {{(TDATA_W - 2 * FIELD_W){1'b0}}, r.at, r.want};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long hold on the result side, counted on its own, so the block backs up
   always @(negedge clock) begin
      if (!stall_done && requests_accepted >= STALL_AT) begin
         stall_left <= STALL_CYCLES;
         stall_done <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // result-side ready with random gaps per idle phase
   always @(negedge clock) begin
      int unsigned idle_pct;
      case (requests_accepted * 3 / PLANNED_ITEMS)
         0:       idle_pct = 81;
         1:       idle_pct = 6;
         default: idle_pct = 0;
      endcase
      rsp_tready <= !reset && stall_left == 0 && $urandom_range(0, 99) >= idle_pct;
   end

   // monitor: predicts on request beats, checks on result beats
   always @(posedge clock) begin
      alloc_request_type r;
      grant_type         want;
      grant_type         got;
      req_beat_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            r.kind = req_tuser;
            r.want = req_tdata[FIELD_W-1:0];
            r.at   = req_tdata[2*FIELD_W-1:FIELD_W];
            expected_grants.push_back(predict_grant(r));
            requests_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser, rsp_tdata[FIELD_W-1:0], rsp_tdata[2*FIELD_W-1:FIELD_W]};
            if (expected_grants.size() == 0) begin
               mismatch_count++;
               $display("%0t: expected no beat, got status %0d offset %0d size %0d",
                        $time, got.status, got.offset, got.size);
            end else begin
               want = expected_grants.pop_front();
               results_checked++;
               if (got.status <= ST_NOT_FOUND) status_seen[got.status]++;
               if (got.status !== want.status || got.offset !== want.offset ||
                   got.size !== want.size) begin
                  mismatch_count++;
                  $write("%0t: expected status %0d offset %0d size %0d, ",
                         $time, want.status, want.offset, want.size);
                  $display("got status %0d offset %0d size %0d",
                           got.status, got.offset, got.size);
               end
            end
         end
      end
   end

   // stimulus, end of run and verdict
   initial begin
      logic [FIELD_W-1:0] value;
      int unsigned        roll;
      int unsigned        free_pct;

      // directed opening; bump offset is tracked by hand in the comments
      queue_request(KIND_ALLOC, '0);                // zero size appended at 0
      queue_request(KIND_ALLOC, '0);                // second block sharing offset 0
      queue_request(KIND_FREE, '0);                 // lowest of the duplicates
      queue_request(KIND_FREE, '0);                 // same block freed twice
      queue_request(KIND_ALLOC, FIELD_W'(100));     // free block too small, append at 0
      queue_request(KIND_ALLOC, '0);                // zero size takes the freed block
      queue_request(KIND_FREE, FIELD_W'(100));      // bump offset, nothing there yet
      queue_request(KIND_ALLOC, FIELD_W'(4000));    // append at 100, bump now 4100
      queue_request(KIND_FREE, FIELD_W'(100));
      queue_request(KIND_ALLOC, FIELD_W'(10));      // reuse of a larger block, size 4000
      queue_request(KIND_ALLOC, '1);                // largest field value
      queue_request(KIND_ALLOC, FIELD_W'(POOL_BYTES + 1));
      queue_request(KIND_ALLOC, FIELD_W'(POOL_BYTES - 4100 + 1));  // one byte past the pool end
      queue_request(KIND_FREE, '1);                 // offset never handed out

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // random part, refilled a few beats ahead so frees can aim at live blocks
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         while (pending_requests.size() >= 4) @(negedge clock);
         free_pct = (n < 1000) ? 25 : 40;
         if ($urandom_range(0, 99) < free_pct) begin
            roll = $urandom_range(0, 9);
            if (slots_used > 0 && roll < 8)
               value = slot_offset[$urandom_range(0, slots_used - 1)];
            else if (roll == 8)
               value = bump_offset;
            else
               value = FIELD_W'($urandom);
            queue_request(KIND_FREE, value);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
               value = FIELD_W'($urandom_range(0, 1024));
            else if (roll < 78)
               value = FIELD_W'($urandom_range(0, 16384));
            else if (roll < 86)
               value = '0;
            else if (roll < 93)
               value = (n < 1000) ? FIELD_W'($urandom_range(0, 16384))
                                  : FIELD_W'($urandom_range(0, 65536));
            else if (roll < 97)
               value = {1'b1, 20'($urandom)};   // at least the whole pool
            else
               value = FIELD_W'($urandom);
            queue_request(KIND_ALLOC, value);
         end
      end

      // exact fit to the pool end, then a zero-size block right at the end
      while (pending_requests.size() != 0 || req_tvalid || expected_grants.size() != 0)
         @(negedge clock);
      value = FIELD_W'(POOL_BYTES - bump_offset);
      queue_request(KIND_ALLOC, value);
      queue_request(KIND_ALLOC, '0);
      queue_request(KIND_FREE, bump_offset);

      // drain, then leave room for a stray late result
      while (pending_requests.size() != 0 || req_tvalid || expected_grants.size() != 0)
         @(negedge clock);
      repeat (TABLE_ENTRIES + 16) @(negedge clock);

      $display("run covered %0d requests and %0d checked results, table at %0d entries, bump %0d",
               requests_accepted, results_checked, slots_used, bump_offset);
      $display("reused %0d, appended %0d, no space %0d, table full %0d, released %0d, not found %0d",
               status_seen[ST_REUSED], status_seen[ST_APPENDED], status_seen[ST_NO_SPACE],
               status_seen[ST_TABLE_FULL], status_seen[ST_RELEASED], status_seen[ST_NOT_FOUND]);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("timeout with %0d results still expected", expected_grants.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

/* first_fit_block_allocator.f */
rtl/ffba_pkg.sv
rtl/ffba_ctrl.sv
rtl/ffba_dpath.sv
rtl/first_fit_block_allocator.sv
tb/sv/tb_top.sv
